/* rtl/core/hsvrgb_pkg.sv */
// Shared types and constants for the HSV to RGB converter.
`default_nettype none

package hsvrgb_pkg;

    localparam int CH_FRAC  = 12;
    localparam int HUE_FRAC = 4;
    localparam int CH_W     = CH_FRAC + 1;
    localparam int HUE_W    = 16;
    localparam int PROD_W   = 2 * CH_W;

    localparam logic [CH_W-1:0]  CH_ONE     = CH_W'(1 << CH_FRAC);
    localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(60 << HUE_FRAC);
    localparam logic [HUE_W-1:0] HUE_FULL   = HUE_W'(360 << HUE_FRAC);
    localparam int NUM_SECTORS = 6;
    localparam int REM_W       = $clog2(60 << HUE_FRAC);

    // ff = rem * ONE / SECTOR via reciprocal; exact for every rem below one sector
    localparam int FF_K = 20;
    localparam longint unsigned FF_RECIP =
        ((64'd1 << (CH_FRAC + FF_K)) + 64'(HUE_SECTOR) - 64'd1) / 64'(HUE_SECTOR);
    localparam int RECIP_W = $clog2(FF_RECIP + 1);
    localparam int FFP_W   = REM_W + RECIP_W;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } hue_sector_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_pixel_t;

    typedef struct packed {
        hue_sector_t     sector;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] val;
    } pix_ctx_t;

    typedef struct packed {
        pix_ctx_t        ctx;
        logic [CH_W-1:0] ff;
    } frac_beat_t;

    typedef struct packed {
        hue_sector_t     sector;
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] q;
        logic [CH_W-1:0] t;
    } pqt_beat_t;

    function automatic logic [CH_W-1:0] fx_mul(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(a) * PROD_W'(b);
        return prod[CH_FRAC +: CH_W];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/hsvrgb_frac.sv */
// Hue split into sector and in-sector fraction, with channel clamping (two stages).
`default_nettype none

module hsvrgb_frac (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire hsvrgb_pkg::hsv_pixel_t in_pix,
    output logic                        out_valid,
    output hsvrgb_pkg::frac_beat_t      out_beat
);

    logic [hsvrgb_pkg::HUE_W-1:0] h_wrap;
    logic [hsvrgb_pkg::HUE_W-1:0] base;
    hsvrgb_pkg::hue_sector_t      sector;
    hsvrgb_pkg::pix_ctx_t         ctx_next;
    logic [hsvrgb_pkg::REM_W-1:0] rem_next;
    logic [hsvrgb_pkg::FFP_W-1:0] ff_prod;

    logic                         s1_valid_reg;
    hsvrgb_pkg::pix_ctx_t         s1_ctx_reg;
    logic [hsvrgb_pkg::REM_W-1:0] s1_rem_reg;
    logic                         s2_valid_reg;
    hsvrgb_pkg::frac_beat_t       s2_beat_reg;

    always_comb begin
        h_wrap = (in_pix.hue >= hsvrgb_pkg::HUE_FULL) ? '0 : in_pix.hue;
        sector = hsvrgb_pkg::SEC_RY;
        base   = '0;
        for (int k = 1; k < hsvrgb_pkg::NUM_SECTORS; k++) begin
            if (h_wrap >= hsvrgb_pkg::HUE_W'(k) * hsvrgb_pkg::HUE_SECTOR) begin
                sector = hsvrgb_pkg::hue_sector_t'(3'(k));
                base   = hsvrgb_pkg::HUE_W'(k) * hsvrgb_pkg::HUE_SECTOR;
            end
        end
        rem_next        = hsvrgb_pkg::REM_W'(h_wrap - base);
        ctx_next.sector = sector;
        ctx_next.sat    = (in_pix.saturation > hsvrgb_pkg::CH_ONE) ?
                          hsvrgb_pkg::CH_ONE : in_pix.saturation;
        ctx_next.val    = (in_pix.brightness > hsvrgb_pkg::CH_ONE) ?
                          hsvrgb_pkg::CH_ONE : in_pix.brightness;
    end

    assign ff_prod = hsvrgb_pkg::FFP_W'(s1_rem_reg) *
                     hsvrgb_pkg::FFP_W'(hsvrgb_pkg::FF_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ctx_reg     <= ctx_next;
            s1_rem_reg     <= rem_next;
            s2_beat_reg.ctx <= s1_ctx_reg;
            s2_beat_reg.ff <= hsvrgb_pkg::CH_W'(ff_prod >> hsvrgb_pkg::FF_K);
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_beat  = s2_beat_reg;

endmodule

`default_nettype wire

/* rtl/core/hsvrgb_pqt.sv */
// p, q and t products from brightness, saturation and fraction (two stages).
`default_nettype none

module hsvrgb_pqt (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   adv,
    input  wire logic                   in_valid,
    input  wire hsvrgb_pkg::frac_beat_t in_beat,
    output logic                        out_valid,
    output hsvrgb_pkg::pqt_beat_t       out_beat
);

    logic                        s3_valid_reg;
    hsvrgb_pkg::pix_ctx_t        s3_ctx_reg;
    logic [hsvrgb_pkg::CH_W-1:0] s3_p_reg;
    logic [hsvrgb_pkg::CH_W-1:0] s3_sf_reg;
    logic [hsvrgb_pkg::CH_W-1:0] s3_sof_reg;
    logic                        s4_valid_reg;
    hsvrgb_pkg::pqt_beat_t       s4_beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_ctx_reg <= in_beat.ctx;
            s3_p_reg   <= hsvrgb_pkg::fx_mul(in_beat.ctx.val,
                                             hsvrgb_pkg::CH_ONE - in_beat.ctx.sat);
            s3_sf_reg  <= hsvrgb_pkg::fx_mul(in_beat.ctx.sat, in_beat.ff);
            s3_sof_reg <= hsvrgb_pkg::fx_mul(in_beat.ctx.sat,
                                             hsvrgb_pkg::CH_ONE - in_beat.ff);

            s4_beat_reg.sector <= s3_ctx_reg.sector;
            s4_beat_reg.val    <= s3_ctx_reg.val;
            s4_beat_reg.p      <= s3_p_reg;
            s4_beat_reg.q      <= hsvrgb_pkg::fx_mul(s3_ctx_reg.val,
                                                     hsvrgb_pkg::CH_ONE - s3_sf_reg);
            s4_beat_reg.t      <= hsvrgb_pkg::fx_mul(s3_ctx_reg.val,
                                                     hsvrgb_pkg::CH_ONE - s3_sof_reg);
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_beat  = s4_beat_reg;

endmodule

`default_nettype wire

/* rtl/core/hsv_to_rgb_converter_unit.sv */
// Top level of the HSV to RGB converter: pipeline, channel select and output register.
//
//  channel | ports                      | beat
//  --------+----------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data   | hsv_pixel_t: hue, saturation, brightness
//  output  | m_valid, m_ready, m_data   | rgb_pixel_t: red, green, blue
//
// One pixel per clock unless the output stalls; stages are sector split, fraction
// multiply, first products, second products, channel select into the output register.
// Throughput is set by the single shared advance enable of the pipeline.
// Reset clears the stage valid bits only.
// When m_valid is high and m_ready low every stage holds; s_ready follows.
`default_nettype none

module hsv_to_rgb_converter_unit (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire hsvrgb_pkg::hsv_pixel_t s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output hsvrgb_pkg::rgb_pixel_t      m_data
);

    logic                   adv;
    logic                   frac_valid;
    hsvrgb_pkg::frac_beat_t frac_beat;
    logic                   pqt_valid;
    hsvrgb_pkg::pqt_beat_t  pqt_beat;
    hsvrgb_pkg::rgb_pixel_t rgb_next;
    logic                   out_valid_reg;
    hsvrgb_pkg::rgb_pixel_t out_data_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    hsvrgb_frac u_frac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_pix    (s_data),
        .out_valid (frac_valid),
        .out_beat  (frac_beat)
    );

    hsvrgb_pqt u_pqt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (frac_valid),
        .in_beat   (frac_beat),
        .out_valid (pqt_valid),
        .out_beat  (pqt_beat)
    );

    always_comb begin
        unique case (pqt_beat.sector)
            hsvrgb_pkg::SEC_RY: rgb_next = '{pqt_beat.val, pqt_beat.t, pqt_beat.p};
            hsvrgb_pkg::SEC_YG: rgb_next = '{pqt_beat.q, pqt_beat.val, pqt_beat.p};
            hsvrgb_pkg::SEC_GC: rgb_next = '{pqt_beat.p, pqt_beat.val, pqt_beat.t};
            hsvrgb_pkg::SEC_CB: rgb_next = '{pqt_beat.p, pqt_beat.q, pqt_beat.val};
            hsvrgb_pkg::SEC_BM: rgb_next = '{pqt_beat.t, pqt_beat.p, pqt_beat.val};
            default:            rgb_next = '{pqt_beat.val, pqt_beat.p, pqt_beat.q};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= pqt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= rgb_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // no channel ever exceeds full scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.red <= hsvrgb_pkg::CH_ONE) &&
                    (m_data.green <= hsvrgb_pkg::CH_ONE) &&
                    (m_data.blue <= hsvrgb_pkg::CH_ONE))
        else $error("output channel above full scale");

    // zero saturation through an unstalled pipeline comes out grey
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.saturation == '0))
            ##1 s_ready ##1 s_ready ##1 s_ready ##1 s_ready
        |=> m_valid && (m_data.red == m_data.green) && (m_data.green == m_data.blue))
        else $error("zero saturation pixel not grey");

    // pipeline advances only while the output register can take a beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data) && $stable(pqt_beat))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire
